// ----- rtl/core/i2c_pkg.sv -----
// ----------------------------------------------------------------------------
// i2c_pkg
// Shared types, widths and limits of the im2col address generator.
// ----------------------------------------------------------------------------
package i2c_pkg;

    // geometry limits
    localparam int MAX_DIM      = 1024;
    localparam int MAX_CHANNELS = 1024;
    localparam int MAX_BATCH    = 256;
    localparam int MAX_KERNEL   = 16;

    // configuration port
    localparam int REG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    // register and counter widths
    localparam int DIM_W   = 11;
    localparam int NB_W    = 9;
    localparam int KERN_W  = 5;
    localparam int STEP_W  = 5;
    localparam int PAD_W   = 4;
    localparam int BATCH_W = 8;
    localparam int CHAN_W  = 10;
    localparam int KCNT_W  = 4;

    // result field widths
    localparam int ROW_IDX_W = 28;
    localparam int COL_IDX_W = 18;
    localparam int SRC_W     = 12;

    // divider iteration counter
    localparam int DIV_CNT_W = $clog2(DIM_W);

    // products used when rebuilding the accumulators
    localparam int CK_W        = CHAN_W + KERN_W;
    localparam int BO_W        = BATCH_W + DIM_W;
    localparam int BASE_PROD_W = DIM_W + STEP_W;
    localparam int COL_FULL_W  = CK_W + KERN_W + 1;
    localparam int ROW_FULL_W  = BO_W + 1 + DIM_W;

    // register indexes
    typedef enum logic [REG_IDX_W-1:0] {
        REG_IN_HEIGHT     = 3'd0,
        REG_IN_WIDTH      = 3'd1,
        REG_CHANNEL_COUNT = 3'd2,
        REG_BATCH_COUNT   = 3'd3,
        REG_KERN_HEIGHT   = 3'd4,
        REG_KERN_WIDTH    = 3'd5,
        REG_STEP_SIZE     = 3'd6,
        REG_PAD_SIZE      = 3'd7
    } reg_idx_t;

    // clamped geometry seen by the datapath
    typedef struct packed {
        logic [DIM_W-1:0]  in_h;
        logic [DIM_W-1:0]  in_w;
        logic [DIM_W-1:0]  chans;
        logic [NB_W-1:0]   batches;
        logic [KERN_W-1:0] k_h;
        logic [KERN_W-1:0] k_w;
        logic [STEP_W-1:0] step;
        logic [PAD_W-1:0]  pad;
        logic [DIM_W-1:0]  span_h;
        logic [DIM_W-1:0]  span_w;
        logic              empty;
    } geom_t;

    // one result word
    typedef struct packed {
        logic [ROW_IDX_W-1:0]    row_index;
        logic [COL_IDX_W-1:0]    col_index;
        logic [BATCH_W-1:0]      batch_index;
        logic [CHAN_W-1:0]       chan_index;
        logic signed [SRC_W-1:0] src_row;
        logic signed [SRC_W-1:0] src_col;
        logic                    is_pad;
        logic                    is_last;
        logic                    is_empty;
    } res_t;

    typedef enum logic {
        DIV_IDLE,
        DIV_RUN
    } div_state_t;

    typedef enum logic [1:0] {
        WK_IDLE,
        WK_MUL1,
        WK_MUL2
    } walk_state_t;

endpackage

// ----- rtl/core/i2c_if.sv -----
// ----------------------------------------------------------------------------
// i2c_if
// Request and result channels of the im2col address generator.
// ----------------------------------------------------------------------------

// request channel
interface i2c_req_if ();
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink (input valid, input restart, output ready);
endinterface

// result channel
interface i2c_res_if import i2c_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [ROW_IDX_W-1:0]    row_index;
    logic [COL_IDX_W-1:0]    col_index;
    logic [BATCH_W-1:0]      batch_index;
    logic [CHAN_W-1:0]       chan_index;
    logic signed [SRC_W-1:0] src_row;
    logic signed [SRC_W-1:0] src_col;
    logic                    is_pad;
    logic                    is_last;
    logic                    is_empty;

    modport source (
        output valid, output row_index, output col_index, output batch_index,
        output chan_index, output src_row, output src_col, output is_pad,
        output is_last, output is_empty, input ready
    );
    modport sink (
        input valid, input row_index, input col_index, input batch_index,
        input chan_index, input src_row, input src_col, input is_pad,
        input is_last, input is_empty, output ready
    );
endinterface

// ----- rtl/core/i2c_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// i2c_cfg_regs
// Configuration registers, range clamping and padded-span computation.
// ----------------------------------------------------------------------------
module i2c_cfg_regs import i2c_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [REG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output geom_t                 geom,
    output logic                  recalc
);

    logic [DIM_W-1:0]  in_height_reg;
    logic [DIM_W-1:0]  in_width_reg;
    logic [DIM_W-1:0]  channel_count_reg;
    logic [NB_W-1:0]   batch_count_reg;
    logic [KERN_W-1:0] kern_height_reg;
    logic [KERN_W-1:0] kern_width_reg;
    logic [STEP_W-1:0] step_size_reg;
    logic [PAD_W-1:0]  pad_size_reg;
    logic              recalc_reg;

    logic [DIM_W-1:0]  pad2;
    logic [DIM_W-1:0]  padded_h;
    logic [DIM_W-1:0]  padded_w;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_height_reg     <= DIM_W'(1);
            in_width_reg      <= DIM_W'(1);
            channel_count_reg <= DIM_W'(1);
            batch_count_reg   <= NB_W'(1);
            kern_height_reg   <= KERN_W'(1);
            kern_width_reg    <= KERN_W'(1);
            step_size_reg     <= STEP_W'(1);
            pad_size_reg      <= '0;
            recalc_reg        <= 1'b0;
        end
        else
        begin
            recalc_reg <= cfg_we;
            if (cfg_we)
            begin
                unique case (reg_idx_t'(cfg_idx))
                    REG_IN_HEIGHT:     in_height_reg     <= cfg_data[DIM_W-1:0];
                    REG_IN_WIDTH:      in_width_reg      <= cfg_data[DIM_W-1:0];
                    REG_CHANNEL_COUNT: channel_count_reg <= cfg_data[DIM_W-1:0];
                    REG_BATCH_COUNT:   batch_count_reg   <= cfg_data[NB_W-1:0];
                    REG_KERN_HEIGHT:   kern_height_reg   <= cfg_data[KERN_W-1:0];
                    REG_KERN_WIDTH:    kern_width_reg    <= cfg_data[KERN_W-1:0];
                    REG_STEP_SIZE:     step_size_reg     <= cfg_data[STEP_W-1:0];
                    REG_PAD_SIZE:      pad_size_reg      <= cfg_data[PAD_W-1:0];
                    default:           pad_size_reg      <= pad_size_reg;
                endcase
            end
        end
    end

    // clamp the registers into their working ranges; step is only kept nonzero, pad passes through
    always_comb
    begin
        geom.in_h = (in_height_reg == '0) ? DIM_W'(1) :
                    (in_height_reg > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : in_height_reg;
        geom.in_w = (in_width_reg == '0) ? DIM_W'(1) :
                    (in_width_reg > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : in_width_reg;
        geom.chans = (channel_count_reg == '0) ? DIM_W'(1) :
                     (channel_count_reg > DIM_W'(MAX_CHANNELS)) ?
                     DIM_W'(MAX_CHANNELS) : channel_count_reg;
        geom.batches = (batch_count_reg == '0) ? NB_W'(1) :
                       (batch_count_reg > NB_W'(MAX_BATCH)) ?
                       NB_W'(MAX_BATCH) : batch_count_reg;
        geom.k_h = (kern_height_reg == '0) ? KERN_W'(1) :
                   (kern_height_reg > KERN_W'(MAX_KERNEL)) ?
                   KERN_W'(MAX_KERNEL) : kern_height_reg;
        geom.k_w = (kern_width_reg == '0) ? KERN_W'(1) :
                   (kern_width_reg > KERN_W'(MAX_KERNEL)) ?
                   KERN_W'(MAX_KERNEL) : kern_width_reg;
        geom.step = (step_size_reg == '0) ? STEP_W'(1) : step_size_reg;
        geom.pad  = pad_size_reg;
    end

    // padded extent, sliding span and the no-output check
    always_comb
    begin
        pad2        = DIM_W'({pad_size_reg, 1'b0});
        padded_h    = geom.in_h + pad2;
        padded_w    = geom.in_w + pad2;
        geom.empty  = (padded_h < DIM_W'(geom.k_h)) || (padded_w < DIM_W'(geom.k_w));
        geom.span_h = padded_h - DIM_W'(geom.k_h);
        geom.span_w = padded_w - DIM_W'(geom.k_w);
    end

    assign recalc = recalc_reg;

endmodule

// ----- rtl/core/i2c_dim_div.sv -----
// ----------------------------------------------------------------------------
// i2c_dim_div
// Restoring divider giving the output height and width, one bit per cycle.
// ----------------------------------------------------------------------------
module i2c_dim_div import i2c_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  geom_t            geom,
    output logic [DIM_W-1:0] out_h,
    output logic [DIM_W-1:0] out_w,
    output logic             busy,
    output logic             done
);

    div_state_t             state_reg;
    div_state_t             state_next;
    logic [DIV_CNT_W-1:0]   cnt_reg;
    logic [DIM_W-1:0]       num_h_reg;
    logic [DIM_W-1:0]       num_w_reg;
    logic [STEP_W-1:0]      rem_h_reg;
    logic [STEP_W-1:0]      rem_w_reg;
    logic [STEP_W-1:0]      dvs_reg;
    logic [DIM_W-1:0]       out_h_reg;
    logic [DIM_W-1:0]       out_w_reg;
    logic [STEP_W+DIM_W-1:0] step_h;
    logic [STEP_W+DIM_W-1:0] step_w;
    logic                   last_iter;

    // one restoring step: returns {remainder, shifted numerator with quotient bit}
    function automatic logic [STEP_W+DIM_W-1:0] div_step(
        input logic [STEP_W-1:0] rem,
        input logic [DIM_W-1:0]  num,
        input logic [STEP_W-1:0] dvs
    );
        logic [STEP_W:0] rsh;
        logic [STEP_W:0] diff;
        logic            ge;
        rsh  = {rem, num[DIM_W-1]};
        diff = rsh - {1'b0, dvs};
        ge   = (rsh >= {1'b0, dvs});
        return {(ge ? diff[STEP_W-1:0] : rsh[STEP_W-1:0]), num[DIM_W-2:0], ge};
    endfunction

    assign step_h    = div_step(rem_h_reg, num_h_reg, dvs_reg);
    assign step_w    = div_step(rem_w_reg, num_w_reg, dvs_reg);
    assign last_iter = (cnt_reg == DIV_CNT_W'(DIM_W - 1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        if (start)
        begin
            state_next = DIV_RUN;
        end
        else
        begin
            unique case (state_reg)
                DIV_IDLE: state_next = DIV_IDLE;
                DIV_RUN:  state_next = last_iter ? DIV_IDLE : DIV_RUN;
                default:  state_next = DIV_IDLE;
            endcase
        end
    end

    // outputs
    always_comb
    begin
        busy = (state_reg == DIV_RUN);
        done = (state_reg == DIV_RUN) && last_iter && !start;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DIV_IDLE;
            cnt_reg   <= '0;
            num_h_reg <= '0;
            num_w_reg <= '0;
            rem_h_reg <= '0;
            rem_w_reg <= '0;
            dvs_reg   <= STEP_W'(1);
            out_h_reg <= DIM_W'(1);
            out_w_reg <= DIM_W'(1);
        end
        else
        begin
            state_reg <= state_next;
            if (start)
            begin
                cnt_reg   <= '0;
                num_h_reg <= geom.span_h;
                num_w_reg <= geom.span_w;
                rem_h_reg <= '0;
                rem_w_reg <= '0;
                dvs_reg   <= geom.step;
            end
            else if (state_reg == DIV_RUN)
            begin
                cnt_reg   <= cnt_reg + 1'b1;
                rem_h_reg <= step_h[STEP_W+DIM_W-1:DIM_W];
                rem_w_reg <= step_w[STEP_W+DIM_W-1:DIM_W];
                num_h_reg <= step_h[DIM_W-1:0];
                num_w_reg <= step_w[DIM_W-1:0];
                // quotient plus one gives the output extent
                if (last_iter)
                begin
                    out_h_reg <= step_h[DIM_W-1:0] + DIM_W'(1);
                    out_w_reg <= step_w[DIM_W-1:0] + DIM_W'(1);
                end
            end
        end
    end

    assign out_h = out_h_reg;
    assign out_w = out_w_reg;

endmodule

// ----- rtl/core/i2c_walker.sv -----
// ----------------------------------------------------------------------------
// i2c_walker
// Loop counters and incremental matrix/source accumulators of the im2col walk.
// ----------------------------------------------------------------------------
module i2c_walker import i2c_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  geom_t            geom,
    input  logic [DIM_W-1:0] out_h,
    input  logic [DIM_W-1:0] out_w,
    input  logic             div_done,
    input  logic             fire,
    input  logic             restart,
    output res_t             res,
    output logic             busy
);

    walk_state_t            state_reg;
    walk_state_t            state_next;

    logic [BATCH_W-1:0]     batch_reg;
    logic [DIM_W-1:0]       orow_reg;
    logic [DIM_W-1:0]       ocol_reg;
    logic [CHAN_W-1:0]      chan_reg;
    logic [KCNT_W-1:0]      krow_reg;
    logic [KCNT_W-1:0]      kcol_reg;
    logic [DIM_W-1:0]       base_row_reg;
    logic [DIM_W-1:0]       base_col_reg;
    logic [ROW_IDX_W-1:0]   row_acc_reg;
    logic [COL_IDX_W-1:0]   col_acc_reg;
    logic [CK_W-1:0]        prod_ck_reg;
    logic [BO_W-1:0]        prod_bo_reg;

    logic [BATCH_W-1:0]     batch_next;
    logic [DIM_W-1:0]       orow_next;
    logic [DIM_W-1:0]       ocol_next;
    logic [CHAN_W-1:0]      chan_next;
    logic [KCNT_W-1:0]      krow_next;
    logic [KCNT_W-1:0]      kcol_next;
    logic [DIM_W-1:0]       base_row_next;
    logic [DIM_W-1:0]       base_col_next;
    logic [ROW_IDX_W-1:0]   row_acc_next;
    logic [COL_IDX_W-1:0]   col_acc_next;
    logic [CK_W-1:0]        prod_ck_next;
    logic [BO_W-1:0]        prod_bo_next;

    logic                   oob;
    logic                   clr;
    logic [BATCH_W-1:0]     cur_batch;
    logic [DIM_W-1:0]       cur_orow;
    logic [DIM_W-1:0]       cur_ocol;
    logic [CHAN_W-1:0]      cur_chan;
    logic [KCNT_W-1:0]      cur_krow;
    logic [KCNT_W-1:0]      cur_kcol;
    logic [DIM_W-1:0]       cur_base_row;
    logic [DIM_W-1:0]       cur_base_col;
    logic [ROW_IDX_W-1:0]   cur_row_acc;
    logic [COL_IDX_W-1:0]   cur_col_acc;
    logic                   kc_end;
    logic                   kr_end;
    logic                   ch_end;
    logic                   oc_end;
    logic                   or_end;
    logic                   b_end;
    logic                   is_last;
    logic [SRC_W:0]         sr_ext;
    logic [SRC_W:0]         sc_ext;
    logic                   is_pad;
    logic [BASE_PROD_W-1:0] base_row_prod;
    logic [BASE_PROD_W-1:0] base_col_prod;
    logic [COL_FULL_W-1:0]  col_full;
    logic [ROW_FULL_W-1:0]  row_full;

    // position check against the current geometry, then restart or out of range
    always_comb
    begin
        oob = ({1'b0, batch_reg} >= geom.batches) || (orow_reg >= out_h) ||
              (ocol_reg >= out_w) || ({1'b0, chan_reg} >= geom.chans) ||
              ({1'b0, krow_reg} >= geom.k_h) || ({1'b0, kcol_reg} >= geom.k_w);
        clr = restart || oob;
        cur_batch    = clr ? '0 : batch_reg;
        cur_orow     = clr ? '0 : orow_reg;
        cur_ocol     = clr ? '0 : ocol_reg;
        cur_chan     = clr ? '0 : chan_reg;
        cur_krow     = clr ? '0 : krow_reg;
        cur_kcol     = clr ? '0 : kcol_reg;
        cur_base_row = clr ? '0 : base_row_reg;
        cur_base_col = clr ? '0 : base_col_reg;
        cur_row_acc  = clr ? '0 : row_acc_reg;
        cur_col_acc  = clr ? '0 : col_acc_reg;
    end

    // loop end flags
    always_comb
    begin
        kc_end  = ({1'b0, cur_kcol} == (geom.k_w - KERN_W'(1)));
        kr_end  = ({1'b0, cur_krow} == (geom.k_h - KERN_W'(1)));
        ch_end  = ({1'b0, cur_chan} == (geom.chans - DIM_W'(1)));
        oc_end  = (cur_ocol == (out_w - DIM_W'(1)));
        or_end  = (cur_orow == (out_h - DIM_W'(1)));
        b_end   = ({1'b0, cur_batch} == (geom.batches - NB_W'(1)));
        is_last = kc_end && kr_end && ch_end && oc_end && or_end && b_end;
    end

    // source coordinates and the padding test
    always_comb
    begin
        sr_ext = (SRC_W+1)'(cur_base_row) + (SRC_W+1)'(cur_krow) - (SRC_W+1)'(geom.pad);
        sc_ext = (SRC_W+1)'(cur_base_col) + (SRC_W+1)'(cur_kcol) - (SRC_W+1)'(geom.pad);
        is_pad = sr_ext[SRC_W] || (sr_ext >= (SRC_W+1)'(geom.in_h)) ||
                 sc_ext[SRC_W] || (sc_ext >= (SRC_W+1)'(geom.in_w));
    end

    // result word
    always_comb
    begin
        if (geom.empty)
        begin
            res          = '0;
            res.is_empty = 1'b1;
        end
        else
        begin
            res.row_index   = cur_row_acc;
            res.col_index   = cur_col_acc;
            res.batch_index = cur_batch;
            res.chan_index  = cur_chan;
            res.src_row     = sr_ext[SRC_W-1:0];
            res.src_col     = sc_ext[SRC_W-1:0];
            res.is_pad      = is_pad;
            res.is_last     = is_last;
            res.is_empty    = 1'b0;
        end
    end

    // products that rebuild base and accumulators after a geometry change
    always_comb
    begin
        base_row_prod = BASE_PROD_W'(orow_reg) * BASE_PROD_W'(geom.step);
        base_col_prod = BASE_PROD_W'(ocol_reg) * BASE_PROD_W'(geom.step);
        col_full = (COL_FULL_W'(prod_ck_reg) + COL_FULL_W'(krow_reg)) * COL_FULL_W'(geom.k_w)
                   + COL_FULL_W'(kcol_reg);
        row_full = (ROW_FULL_W'(prod_bo_reg) + ROW_FULL_W'(orow_reg)) * ROW_FULL_W'(out_w)
                   + ROW_FULL_W'(ocol_reg);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        if (div_done)
        begin
            state_next = WK_MUL1;
        end
        else
        begin
            unique case (state_reg)
                WK_IDLE: state_next = WK_IDLE;
                WK_MUL1: state_next = WK_MUL2;
                WK_MUL2: state_next = WK_IDLE;
                default: state_next = WK_IDLE;
            endcase
        end
    end

    // outputs
    always_comb
    begin
        busy = (state_reg != WK_IDLE);
    end

    // counter and accumulator updates
    always_comb
    begin
        batch_next    = batch_reg;
        orow_next     = orow_reg;
        ocol_next     = ocol_reg;
        chan_next     = chan_reg;
        krow_next     = krow_reg;
        kcol_next     = kcol_reg;
        base_row_next = base_row_reg;
        base_col_next = base_col_reg;
        row_acc_next  = row_acc_reg;
        col_acc_next  = col_acc_reg;
        prod_ck_next  = prod_ck_reg;
        prod_bo_next  = prod_bo_reg;
        unique case (state_reg)
            WK_MUL1:
            begin
                prod_ck_next  = CK_W'(chan_reg) * CK_W'(geom.k_h);
                prod_bo_next  = BO_W'(batch_reg) * BO_W'(out_h);
                base_row_next = base_row_prod[DIM_W-1:0];
                base_col_next = base_col_prod[DIM_W-1:0];
            end
            WK_MUL2:
            begin
                col_acc_next = col_full[COL_IDX_W-1:0];
                row_acc_next = row_full[ROW_IDX_W-1:0];
            end
            WK_IDLE:
            begin
                if (fire)
                begin
                    if (geom.empty || is_last)
                    begin
                        batch_next    = '0;
                        orow_next     = '0;
                        ocol_next     = '0;
                        chan_next     = '0;
                        krow_next     = '0;
                        kcol_next     = '0;
                        base_row_next = '0;
                        base_col_next = '0;
                        row_acc_next  = '0;
                        col_acc_next  = '0;
                    end
                    else
                    begin
                        // kernel column, kernel row, channel ripple
                        kcol_next    = kc_end ? '0 : cur_kcol + 1'b1;
                        krow_next    = !kc_end ? cur_krow : (kr_end ? '0 : cur_krow + 1'b1);
                        chan_next    = !(kc_end && kr_end) ? cur_chan :
                                       (ch_end ? '0 : cur_chan + 1'b1);
                        col_acc_next = (kc_end && kr_end && ch_end) ? '0 :
                                       cur_col_acc + 1'b1;
                        // output position advances once per full row of the matrix
                        row_acc_next = (kc_end && kr_end && ch_end) ?
                                       cur_row_acc + 1'b1 : cur_row_acc;
                        ocol_next     = cur_ocol;
                        base_col_next = cur_base_col;
                        orow_next     = cur_orow;
                        base_row_next = cur_base_row;
                        batch_next    = cur_batch;
                        if (kc_end && kr_end && ch_end)
                        begin
                            ocol_next     = oc_end ? '0 : cur_ocol + 1'b1;
                            base_col_next = oc_end ? '0 : cur_base_col + DIM_W'(geom.step);
                            if (oc_end)
                            begin
                                orow_next     = or_end ? '0 : cur_orow + 1'b1;
                                base_row_next = or_end ? '0 :
                                                cur_base_row + DIM_W'(geom.step);
                                if (or_end)
                                begin
                                    batch_next = cur_batch + 1'b1;
                                end
                            end
                        end
                    end
                end
            end
            default:
            begin
                batch_next = batch_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= WK_IDLE;
            batch_reg    <= '0;
            orow_reg     <= '0;
            ocol_reg     <= '0;
            chan_reg     <= '0;
            krow_reg     <= '0;
            kcol_reg     <= '0;
            base_row_reg <= '0;
            base_col_reg <= '0;
            row_acc_reg  <= '0;
            col_acc_reg  <= '0;
            prod_ck_reg  <= '0;
            prod_bo_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            batch_reg    <= batch_next;
            orow_reg     <= orow_next;
            ocol_reg     <= ocol_next;
            chan_reg     <= chan_next;
            krow_reg     <= krow_next;
            kcol_reg     <= kcol_next;
            base_row_reg <= base_row_next;
            base_col_reg <= base_col_next;
            row_acc_reg  <= row_acc_next;
            col_acc_reg  <= col_acc_next;
            prod_ck_reg  <= prod_ck_next;
            prod_bo_reg  <= prod_bo_next;
        end
    end

endmodule

// ----- rtl/core/i2c_out_buf.sv -----
// ----------------------------------------------------------------------------
// i2c_out_buf
// Result register with a skid stage, so input and output stalls are decoupled.
// ----------------------------------------------------------------------------
module i2c_out_buf import i2c_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  res_t in_data,
    output logic in_space,
    output logic out_valid,
    output res_t out_data,
    input  logic out_ready
);

    logic out_valid_reg;
    logic out_valid_next;
    res_t out_data_reg;
    res_t out_data_next;
    logic skid_valid_reg;
    logic skid_valid_next;
    res_t skid_data_reg;
    res_t skid_data_next;
    logic out_free;

    // move words between input, skid and output registers
    always_comb
    begin
        out_free        = !out_valid_reg || out_ready;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (out_free)
        begin
            out_valid_next  = skid_valid_reg || in_valid;
            out_data_next   = skid_valid_reg ? skid_data_reg : in_data;
            skid_valid_next = 1'b0;
        end
        else if (in_valid)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = in_data;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign in_space  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ----- rtl/core/im2col_address_generator_core.sv -----
// ----------------------------------------------------------------------------
// im2col_address_generator_core
// Walks the im2col lowering of a convolution, one element per request word.
// ----------------------------------------------------------------------------
// result: an accepted request's word is registered in the output buffer (skid on stall)
// throughput: one request per cycle while ready is high; counters and accumulators
// step incrementally; ready is low while the skid register is full and, after any
// register write, while the output extents are divided out one quotient bit at a
// time and the accumulators are rebuilt in the multiply states WK_MUL1 and WK_MUL2
// reset: registers take their reset values, the walk starts at the first element
module im2col_address_generator_core import i2c_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [REG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    i2c_req_if.sink               req,
    i2c_res_if.source             rsp
);

    geom_t            geom;
    logic             recalc;
    logic [DIM_W-1:0] out_h;
    logic [DIM_W-1:0] out_w;
    logic             div_busy;
    logic             div_done;
    logic             walk_busy;
    logic             fire;
    logic             space;
    res_t             walk_res;
    res_t             out_res;

    i2c_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .geom     (geom),
        .recalc   (recalc)
    );

    i2c_dim_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (recalc),
        .geom  (geom),
        .out_h (out_h),
        .out_w (out_w),
        .busy  (div_busy),
        .done  (div_done)
    );

    // request handshake
    assign req.ready = space && !recalc && !div_busy && !walk_busy;
    assign fire      = req.valid && req.ready;

    i2c_walker u_walk (
        .clk      (clk),
        .rst_n    (rst_n),
        .geom     (geom),
        .out_h    (out_h),
        .out_w    (out_w),
        .div_done (div_done),
        .fire     (fire),
        .restart  (req.restart),
        .res      (walk_res),
        .busy     (walk_busy)
    );

    i2c_out_buf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fire),
        .in_data   (walk_res),
        .in_space  (space),
        .out_valid (rsp.valid),
        .out_data  (out_res),
        .out_ready (rsp.ready)
    );

    // result fields
    assign rsp.row_index   = out_res.row_index;
    assign rsp.col_index   = out_res.col_index;
    assign rsp.batch_index = out_res.batch_index;
    assign rsp.chan_index  = out_res.chan_index;
    assign rsp.src_row     = out_res.src_row;
    assign rsp.src_col     = out_res.src_col;
    assign rsp.is_pad      = out_res.is_pad;
    assign rsp.is_last     = out_res.is_last;
    assign rsp.is_empty    = out_res.is_empty;

endmodule
